### rtl/core/lsg_pkg.sv
// ---------------------------------------------------------------------------
// lsg_pkg
// Shared types and constants for the sum-of-twelve Gaussian noise generator.
// ---------------------------------------------------------------------------
package lsg_pkg;

    // Data widths
    localparam int WORD_W   = 32;
    localparam int SAMPLE_W = 36;
    localparam int DRAW_U_W = 24;

    // Run length and draw count
    localparam int MAX_RUN          = 64;
    localparam int RUN_W            = 7;
    localparam int DRAWS_PER_SAMPLE = 12;
    localparam int DRAW_W           = 4;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    // Configuration port
    localparam int CFG_IDX_W = 3;

    // Six in fixed point with 32 fraction bits
    localparam logic [SAMPLE_W-1:0] SIX_UNITS = 36'h6_0000_0000;

    // Reset values of the configuration registers
    localparam logic [WORD_W-1:0] MULT_MAIN_RST   = 32'd1664525;
    localparam logic [WORD_W-1:0] INCR_MAIN_RST   = 32'd1013904223;
    localparam logic [WORD_W-1:0] MULT_SECOND_RST = 32'd69069;
    localparam logic [WORD_W-1:0] INCR_SECOND_RST = 32'd3;
    localparam logic [WORD_W-1:0] SEED_RST        = 32'd0;

    // Generator modes
    localparam logic MODE_COMBINED = 1'b0;
    localparam logic MODE_SINGLE   = 1'b1;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE        = 3'd0,
        REG_MULT_MAIN   = 3'd1,
        REG_INCR_MAIN   = 3'd2,
        REG_MULT_SECOND = 3'd3,
        REG_INCR_SECOND = 3'd4,
        REG_SEED_MAIN   = 3'd5,
        REG_SEED_SECOND = 3'd6,
        REG_SKIP_SEED   = 3'd7
    } cfg_index_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_ADD,
        B_EMIT
    } back_state_t;

    // Generator coefficients
    typedef struct packed {
        logic              mode;
        logic [WORD_W-1:0] mult_main;
        logic [WORD_W-1:0] incr_main;
        logic [WORD_W-1:0] mult_second;
        logic [WORD_W-1:0] incr_second;
    } gen_cfg_t;

    // State word reload strobes
    typedef struct packed {
        logic              load_main;
        logic              load_second;
        logic              load_skip;
        logic [WORD_W-1:0] value;
    } seed_load_t;

    // Queue status
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

### rtl/core/lsg_regs.sv
// ---------------------------------------------------------------------------
// lsg_regs
// Configuration register file; seed writes are forwarded as reload strobes.
// ---------------------------------------------------------------------------
module lsg_regs
    import lsg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    output gen_cfg_t             gen_cfg,
    output seed_load_t           seed_load
);

    gen_cfg_t gen_cfg_reg;
    gen_cfg_t gen_cfg_next;

    // Coefficient writes
    always_comb begin
        gen_cfg_next = gen_cfg_reg;
        if (cfg_write) begin
            case (cfg_index_t'(cfg_index))
                REG_MODE:        gen_cfg_next.mode        = cfg_data[0];
                REG_MULT_MAIN:   gen_cfg_next.mult_main   = cfg_data;
                REG_INCR_MAIN:   gen_cfg_next.incr_main   = cfg_data;
                REG_MULT_SECOND: gen_cfg_next.mult_second = cfg_data;
                REG_INCR_SECOND: gen_cfg_next.incr_second = cfg_data;
                default:         gen_cfg_next = gen_cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_cfg_reg.mode        <= MODE_COMBINED;
            gen_cfg_reg.mult_main   <= MULT_MAIN_RST;
            gen_cfg_reg.incr_main   <= INCR_MAIN_RST;
            gen_cfg_reg.mult_second <= MULT_SECOND_RST;
            gen_cfg_reg.incr_second <= INCR_SECOND_RST;
        end else begin
            gen_cfg_reg <= gen_cfg_next;
        end
    end

    // Seed writes reload the generator state directly
    always_comb begin
        seed_load.load_main   = cfg_write && (cfg_index_t'(cfg_index) == REG_SEED_MAIN);
        seed_load.load_second = cfg_write && (cfg_index_t'(cfg_index) == REG_SEED_SECOND);
        seed_load.load_skip   = cfg_write && (cfg_index_t'(cfg_index) == REG_SKIP_SEED);
        seed_load.value       = cfg_data;
    end

    assign gen_cfg = gen_cfg_reg;

endmodule

### rtl/core/lsg_front.sv
// ---------------------------------------------------------------------------
// lsg_front
// Request intake: drops empty runs, clamps long runs, feeds the queue.
// ---------------------------------------------------------------------------
module lsg_front
    import lsg_pkg::*;
(
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [RUN_W-1:0] s_sample_count,
    input  queue_status_t    q_status,
    output logic             push,
    output logic [RUN_W-1:0] push_count
);

    localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(MAX_RUN);

    logic empty_run;

    // Classify the request
    always_comb begin
        empty_run  = (s_sample_count == '0);
        push_count = (s_sample_count > RUN_MAX) ? RUN_MAX : s_sample_count;
    end

    // Empty runs are taken and discarded
    assign s_ready = !q_status.full;
    assign push    = s_valid && !q_status.full && !empty_run;

endmodule

### rtl/core/lsg_queue.sv
// ---------------------------------------------------------------------------
// lsg_queue
// Short FIFO of run lengths between the front and back ends.
// ---------------------------------------------------------------------------
module lsg_queue
    import lsg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [RUN_W-1:0] push_count,
    input  logic             pop,
    output logic [RUN_W-1:0] pop_count,
    output queue_status_t    q_status
);

    logic [RUN_W-1:0]  mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   fill_reg;
    logic [QPTR_W:0]   fill_next;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_count;
        end
    end

    assign pop_count      = mem_reg[rd_ptr_reg];
    assign q_status.full  = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_status.empty = (fill_reg == '0);

endmodule

### rtl/core/lsg_back.sv
// ---------------------------------------------------------------------------
// lsg_back
// Generator sequencer: steps the LCGs twelve times per sample, accumulates
// the draws and hands each finished sample to the output register.
// ---------------------------------------------------------------------------
module lsg_back
    import lsg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  gen_cfg_t            gen_cfg,
    input  seed_load_t          seed_load,
    input  queue_status_t       q_status,
    input  logic [RUN_W-1:0]    pop_count,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SAMPLE_W-1:0] m_sample,
    output logic                m_last
);

    localparam logic [DRAW_W-1:0] LAST_DRAW = DRAW_W'(DRAWS_PER_SAMPLE - 1);

    back_state_t state_reg;
    back_state_t state_next;

    logic [WORD_W-1:0]   main_reg,      main_next;
    logic [WORD_W-1:0]   second_reg,    second_next;
    logic [WORD_W-1:0]   skip_reg,      skip_next;
    logic [WORD_W-1:0]   prod_main_reg, prod_main_next;
    logic [WORD_W-1:0]   prod_sec_reg,  prod_sec_next;
    logic [SAMPLE_W-1:0] acc_reg,       acc_next;
    logic [DRAW_W-1:0]   draw_reg,      draw_next;
    logic [RUN_W-1:0]    left_reg,      left_next;
    logic [SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic                out_last_reg,   out_last_next;
    logic                out_valid_reg,  out_valid_next;

    logic                  can_load;
    logic [WORD_W-1:0]     main_new;
    logic [WORD_W-1:0]     sec_new;
    logic [WORD_W-1:0]     diff;
    logic                  skip_hit;
    logic [DRAW_U_W-1:0]   draw_u;
    logic [SAMPLE_W-1:0]   sample_val;

    assign can_load = !out_valid_reg || m_ready;

    // Draw arithmetic on the registered products
    always_comb begin
        main_new = prod_main_reg + gen_cfg.incr_main;
        sec_new  = prod_sec_reg + gen_cfg.incr_second;
        diff     = main_new - sec_new;
        skip_hit = (sec_new == skip_reg);
        draw_u   = {diff[WORD_W-1:9], 1'b1};
        if (gen_cfg.mode == MODE_SINGLE) begin
            sample_val = acc_reg - SIX_UNITS;
        end else begin
            sample_val = SIX_UNITS - {acc_reg[SAMPLE_W-9:0], 8'd0};
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (!q_status.empty) begin
                    state_next = B_MUL;
                end
            end
            B_MUL: begin
                state_next = B_ADD;
            end
            B_ADD: begin
                if (draw_reg == LAST_DRAW) begin
                    state_next = B_EMIT;
                end else begin
                    state_next = B_MUL;
                end
            end
            B_EMIT: begin
                if (can_load) begin
                    state_next = (left_reg == RUN_W'(1)) ? B_IDLE : B_MUL;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        pop             = 1'b0;
        main_next       = main_reg;
        second_next     = second_reg;
        skip_next       = skip_reg;
        prod_main_next  = prod_main_reg;
        prod_sec_next   = prod_sec_reg;
        acc_next        = acc_reg;
        draw_next       = draw_reg;
        left_next       = left_reg;
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_ready;

        case (state_reg)
            B_IDLE: begin
                if (!q_status.empty) begin
                    pop       = 1'b1;
                    left_next = pop_count;
                    acc_next  = '0;
                    draw_next = '0;
                end
            end
            B_MUL: begin
                prod_main_next = main_reg * gen_cfg.mult_main;
                prod_sec_next  = second_reg * gen_cfg.mult_second;
            end
            B_ADD: begin
                main_next = main_new;
                draw_next = draw_reg + 1'b1;
                if (gen_cfg.mode == MODE_SINGLE) begin
                    acc_next = acc_reg + {{(SAMPLE_W-WORD_W){1'b0}}, main_new};
                end else begin
                    acc_next = acc_reg + {{(SAMPLE_W-DRAW_U_W){1'b0}}, draw_u};
                    if (skip_hit) begin
                        second_next = sec_new + 1'b1;
                        skip_next   = skip_reg + 1'b1;
                    end else begin
                        second_next = sec_new;
                    end
                end
            end
            B_EMIT: begin
                if (can_load) begin
                    out_sample_next = sample_val;
                    out_last_next   = (left_reg == RUN_W'(1));
                    out_valid_next  = 1'b1;
                    left_next       = left_reg - 1'b1;
                    acc_next        = '0;
                    draw_next       = '0;
                end
            end
            default: begin
                pop = 1'b0;
            end
        endcase

        // Seed reloads; the user must write seeds only while idle, the block itself does not enforce it
        if (seed_load.load_main) begin
            main_next = seed_load.value;
        end
        if (seed_load.load_second) begin
            second_next = seed_load.value;
        end
        if (seed_load.load_skip) begin
            skip_next = seed_load.value;
        end
    end

    // Control and generator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            main_reg      <= SEED_RST;
            second_reg    <= SEED_RST;
            skip_reg      <= SEED_RST;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            main_reg      <= main_next;
            second_reg    <= second_next;
            skip_reg      <= skip_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        prod_main_reg  <= prod_main_next;
        prod_sec_reg   <= prod_sec_next;
        acc_reg        <= acc_next;
        draw_reg       <= draw_next;
        left_reg       <= left_next;
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_sample = out_sample_reg;
    assign m_last   = out_last_reg;

endmodule

### rtl/core/lcg_sum12_gaussian_generator.sv
// ---------------------------------------------------------------------------
// lcg_sum12_gaussian_generator
// Approximate Gaussian noise source built from sums of twelve LCG draws.
// ---------------------------------------------------------------------------
// Each request on the s_ channel asks for a run of sample_count samples
// (zero gives nothing, counts above 64 give 64); samples leave on the m_
// channel as 36-bit two's complement values with 32 fraction bits, and the
// final sample of each run has m_last set. Each draw is handled in the back
// end first by the pair of 32x32 multipliers and then by the increment,
// combine and accumulate, and each finished sample is then handed to the
// output register. A two-entry request queue lets new requests be taken
// while a run is in progress. Configuration is written through the cfg_
// port, which is always ready; writes must only happen while no run is
// pending, and writing a seed register reloads the matching generator
// state word.
// ---------------------------------------------------------------------------
module lcg_sum12_gaussian_generator
    import lsg_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    // Configuration write channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [WORD_W-1:0]          cfg_data,
    // Request channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [RUN_W-1:0]           s_sample_count,
    // Sample channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_sample,
    output logic                       m_last
);

    gen_cfg_t            gen_cfg;
    seed_load_t          seed_load;
    queue_status_t       q_status;
    logic                push;
    logic [RUN_W-1:0]    push_count;
    logic                pop;
    logic [RUN_W-1:0]    pop_count;
    logic [SAMPLE_W-1:0] sample_bits;

    assign cfg_ready = 1'b1;

    // Register file
    lsg_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .gen_cfg   (gen_cfg),
        .seed_load (seed_load)
    );

    // Request intake
    lsg_front u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_count (s_sample_count),
        .q_status       (q_status),
        .push           (push),
        .push_count     (push_count)
    );

    // Request queue
    lsg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_count (push_count),
        .pop        (pop),
        .pop_count  (pop_count),
        .q_status   (q_status)
    );

    // Generator sequencer
    lsg_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .gen_cfg   (gen_cfg),
        .seed_load (seed_load),
        .q_status  (q_status),
        .pop_count (pop_count),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_sample  (sample_bits),
        .m_last    (m_last)
    );

    assign m_sample = $signed(sample_bits);

endmodule

### tb/gaussian_sample_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gaussian_sample_checker
// Watches the configuration, request and sample channels of the sum-of-twelve
// Gaussian generator. It keeps its own copy of the generator coefficients and
// state words, turns every accepted request into the run of samples it must
// produce, and compares each sample transaction against the oldest one.
// ---------------------------------------------------------------------------
module gaussian_sample_checker
    import lsg_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [WORD_W-1:0]          cfg_data,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [RUN_W-1:0]           s_sample_count,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic signed [SAMPLE_W-1:0] m_sample,
    input  logic                       m_last,
    output int unsigned                fail_count,
    output int unsigned                outstanding
);

    // Keep the log readable when the design is badly broken
    localparam int unsigned MAX_PRINTS = 30;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } gauss_result_t;

    gauss_result_t expected_samples[$];

    // Coefficients and generator state as the design should hold them
    logic              gen_mode;
    logic [WORD_W-1:0] mult_main;
    logic [WORD_W-1:0] incr_main;
    logic [WORD_W-1:0] mult_second;
    logic [WORD_W-1:0] incr_second;
    logic [WORD_W-1:0] main_word;
    logic [WORD_W-1:0] second_word;
    logic [WORD_W-1:0] skip_mark;

    int unsigned sample_index;

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string what);
        if (fail_count < MAX_PRINTS)
            $display("%0t ns: sample %0d: %s", $time, sample_index, what);
        fail_count++;
    endtask

    // Twelve draws from the generators, advancing the state words
    function automatic logic [SAMPLE_W-1:0] draw_gaussian_sample();
        logic [SAMPLE_W-1:0] acc;
        logic [WORD_W-1:0]   diff;
        logic [DRAW_U_W-1:0] draw;
        int                  k;
        acc = '0;
        if (gen_mode == MODE_SINGLE) begin
            for (k = 0; k < DRAWS_PER_SAMPLE; k++) begin
                main_word = main_word * mult_main + incr_main;
                acc = acc + SAMPLE_W'(main_word);
            end
            return acc - SIX_UNITS;
        end
        for (k = 0; k < DRAWS_PER_SAMPLE; k++) begin
            main_word   = main_word * mult_main + incr_main;
            second_word = second_word * mult_second + incr_second;
            diff = main_word - second_word;
            // skip mark hit: second generator and mark both step past it
            if (second_word == skip_mark) begin
                second_word = second_word + 1'b1;
                skip_mark   = skip_mark + 1'b1;
            end
            draw = diff[WORD_W-1:WORD_W-DRAW_U_W] | DRAW_U_W'(1);
            acc  = acc + SAMPLE_W'(draw);
        end
        return SIX_UNITS - (acc << 8);
    endfunction

    always @(posedge aclk) begin
        gauss_result_t want;
        int            run_len;
        int            k;
        if (!aresetn) begin
            gen_mode     = MODE_COMBINED;
            mult_main    = MULT_MAIN_RST;
            incr_main    = INCR_MAIN_RST;
            mult_second  = MULT_SECOND_RST;
            incr_second  = INCR_SECOND_RST;
            main_word    = SEED_RST;
            second_word  = SEED_RST;
            skip_mark    = SEED_RST;
            sample_index = 0;
            expected_samples.delete();
        end else begin
            // Register write transaction
            if (cfg_valid && cfg_ready) begin
                case (cfg_index_t'(cfg_index))
                    REG_MODE:        gen_mode    = cfg_data[0];
                    REG_MULT_MAIN:   mult_main   = cfg_data;
                    REG_INCR_MAIN:   incr_main   = cfg_data;
                    REG_MULT_SECOND: mult_second = cfg_data;
                    REG_INCR_SECOND: incr_second = cfg_data;
                    REG_SEED_MAIN:   main_word   = cfg_data;
                    REG_SEED_SECOND: second_word = cfg_data;
                    REG_SKIP_SEED:   skip_mark   = cfg_data;
                    default: ;
                endcase
            end

            // Request transaction: queue the whole run, count saturates
            if (s_valid && s_ready) begin
                run_len = (s_sample_count > MAX_RUN) ? MAX_RUN : int'(s_sample_count);
                for (k = 0; k < run_len; k++) begin
                    want.sample = draw_gaussian_sample();
                    want.last   = (k == run_len - 1);
                    expected_samples.push_back(want);
                end
            end

            // Sample transaction
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch($sformatf("unexpected sample %0d last %0b",
                                              m_sample, m_last));
                end else begin
                    want = expected_samples.pop_front();
                    if (m_sample !== want.sample)
                        report_mismatch($sformatf("sample %0d, expected %0d",
                                                  m_sample, $signed(want.sample)));
                    if (m_last !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  m_last, want.last));
                end
                sample_index++;
            end
        end
        outstanding <= expected_samples.size();
    end

endmodule

### tb/tb_lcg_sum12_gaussian_generator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_lcg_sum12_gaussian_generator
// Stimulus and verdict for the sum-of-twelve Gaussian noise generator.
// ---------------------------------------------------------------------------
// Programs the generator through several coefficient and seed settings, sends
// directed runs (zero, one, full and saturated counts, extreme samples, the
// skip mark firing on every draw) and then random runs, with random gaps on
// both channels, one quiet stretch and one long output hold-off. All checking
// is done in gaussian_sample_checker.
// ---------------------------------------------------------------------------
module tb_lcg_sum12_gaussian_generator;
    import lsg_pkg::*;

    localparam int          RANDOM_PHASES    = 8;
    localparam int          REQS_PER_PHASE   = 52;
    localparam int          QUIET_PHASE      = 2;
    localparam int          PRESSURE_PHASE   = 5;
    localparam int unsigned HOLD_CYCLES      = 2000;
    localparam int unsigned SETTLE_CYCLES    = 64;
    localparam int unsigned DRAIN_LIMIT      = 100000;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [WORD_W-1:0]          cfg_data = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [RUN_W-1:0]           s_sample_count = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] m_sample;
    logic                       m_last;

    int unsigned fail_count;
    int unsigned outstanding;

    // Sink control
    logic        no_idle = 1'b0;
    int unsigned holds_asked = 0;
    int unsigned holds_served = 0;
    int unsigned hold_left = 0;

    // Clock, 12 ns period
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    lcg_sum12_gaussian_generator uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_count (s_sample_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample       (m_sample),
        .m_last         (m_last)
    );

    gaussian_sample_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_count (s_sample_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample       (m_sample),
        .m_last         (m_last),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    // Sample sink: random stalls, plus a long hold-off when asked
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != holds_asked) begin
            m_ready      <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_asked;
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= 7);
        end
    end

    // Register write transaction; valid is left high for a following write
    task automatic write_register(input cfg_index_t index, input logic [WORD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic program_generator(
        input logic [WORD_W-1:0] mode_data,
        input logic [WORD_W-1:0] mm, input logic [WORD_W-1:0] im,
        input logic [WORD_W-1:0] ms, input logic [WORD_W-1:0] is,
        input logic [WORD_W-1:0] sm, input logic [WORD_W-1:0] ss,
        input logic [WORD_W-1:0] sk
    );
        write_register(REG_MODE, mode_data);
        write_register(REG_MULT_MAIN, mm);
        write_register(REG_INCR_MAIN, im);
        write_register(REG_MULT_SECOND, ms);
        write_register(REG_INCR_SECOND, is);
        write_register(REG_SEED_MAIN, sm);
        write_register(REG_SEED_SECOND, ss);
        write_register(REG_SKIP_SEED, sk);
        cfg_valid <= 1'b0;
    endtask

    // Request transaction with a random gap in front of it
    task automatic offer_request(input logic [RUN_W-1:0] count);
        while (!no_idle && $urandom_range(99) < 7) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_sample_count <= count;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Wait for every expected sample, then let a dropped request settle
    task automatic wait_until_idle();
        int unsigned waited;
        waited = 0;
        do begin
            @(posedge aclk);
            waited++;
        end while (outstanding != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 32'd1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly short runs, with some long, zero and saturating counts
    function automatic logic [RUN_W-1:0] random_count();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 4) return '0;
        if (r < 8) return RUN_W'($urandom_range(MAX_RUN + 1, 127));
        if (r < 14) return RUN_W'($urandom_range(33, MAX_RUN));
        if (r < 30) return RUN_W'($urandom_range(9, 32));
        return RUN_W'($urandom_range(1, 8));
    endfunction

    initial begin
        int                phase;
        logic [WORD_W-1:0] mode_data;
        logic [WORD_W-1:0] ms;
        logic [WORD_W-1:0] is;
        logic [WORD_W-1:0] ss;
        logic [WORD_W-1:0] sk;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset coefficients: single, zero, full and saturated runs
        offer_request(7'd1);
        offer_request(7'd0);
        offer_request(7'd2);
        offer_request(7'd64);
        offer_request(7'd65);
        offer_request(7'd127);
        s_valid <= 1'b0;
        wait_until_idle();

        // Single mode, main word stuck at all ones: largest sample
        program_generator(32'hFFFF_FFFF, 32'd1, 32'd0, '1, '1, '1, $urandom, $urandom);
        offer_request(7'd2);
        offer_request(7'd1);
        s_valid <= 1'b0;
        wait_until_idle();

        // Single mode, main word stuck at zero: smallest sample
        program_generator({31'd0, MODE_SINGLE}, 32'd0, 32'd0, 32'd5, 32'd7, 32'd0, 32'd9, 32'd9);
        offer_request(7'd1);
        s_valid <= 1'b0;
        wait_until_idle();

        // Combined, second generator holds its word: skip mark matched on every draw
        program_generator(32'hFFFF_FFFE, 32'd0, 32'd5, 32'd1, 32'd0, 32'd0, 32'd5, 32'd5);
        offer_request(7'd3);
        s_valid <= 1'b0;
        wait_until_idle();

        // Combined, difference all ones: most negative combined sample
        program_generator({31'd0, MODE_COMBINED}, 32'd0, '1, 32'd0, 32'd0, '1, '1, '1);
        offer_request(7'd2);
        s_valid <= 1'b0;
        wait_until_idle();

        // Combined, all-ones coefficients and seeds
        program_generator({31'h2AAA_AAAA, MODE_COMBINED}, '1, '1, '1, '1, '1, '1, $urandom);
        offer_request(7'd4);
        offer_request(7'd3);
        s_valid <= 1'b0;
        wait_until_idle();

        // Random phases, each with fresh coefficients and seeds
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            mode_data    = $urandom;
            mode_data[0] = (phase % 2 == 0) ? MODE_COMBINED : MODE_SINGLE;
            ss = $urandom;
            if (phase % 4 == 0) begin
                // second generator pinned to its increment, which starts as the skip mark
                ms = '0;
                is = $urandom;
                sk = is;
            end else begin
                ms = pick_word();
                is = pick_word();
                sk = ($urandom_range(1) == 0) ? ss : $urandom;
            end
            program_generator(mode_data, pick_word(), pick_word(), ms, is,
                              $urandom, ss, sk);
            if (phase == QUIET_PHASE)
                no_idle <= 1'b1;
            if (phase == PRESSURE_PHASE)
                holds_asked <= holds_asked + 1;
            repeat (REQS_PER_PHASE) offer_request(random_count());
            s_valid <= 1'b0;
            no_idle <= 1'b0;
            wait_until_idle();
        end

        if (fail_count == 0 && outstanding == 0) begin
            $display("tb_lcg_sum12_gaussian_generator passed");
        end else begin
            $display("tb_lcg_sum12_gaussian_generator failed");
        end
        $finish;
    end

    // Run limit
    initial begin
        #48_000_000;
        $display("tb_lcg_sum12_gaussian_generator failed");
        $finish;
    end

endmodule

### files.f
rtl/core/lsg_pkg.sv
rtl/core/lsg_regs.sv
rtl/core/lsg_front.sv
rtl/core/lsg_queue.sv
rtl/core/lsg_back.sv
rtl/core/lcg_sum12_gaussian_generator.sv
tb/gaussian_sample_checker.sv
tb/tb_lcg_sum12_gaussian_generator.sv
